[design/paeb_pkg.sv]
// Shared types and constants for the polyphonic ADSR envelope bank.
// Request/result words, per-voice memory entry, phase and sequencer codes.
// No dependencies.
`default_nettype none

package paeb_pkg;

	// Widths fixed by the field definitions
	localparam int unsigned LEVEL_W = 32;
	localparam int unsigned TICK_W  = 18;
	localparam int unsigned AMP_W   = 16;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned CFG_W   = 32;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 32'hFFFF_FFFF;

	// Operation codes
	localparam logic [1:0] FUNC_PRESS   = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_TICK    = 2'd2;
	localparam logic [1:0] FUNC_NONE    = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_ATTACK  = 2'd0;
	localparam logic [1:0] CFG_DECAY   = 2'd1;
	localparam logic [1:0] CFG_SUSTAIN = 2'd2;
	localparam logic [1:0] CFG_RELEASE = 2'd3;

	typedef enum logic [2:0] {
		PH_OFF     = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_STEP,
		S_AMPGO,
		S_AMP,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] voice;
	} req_t;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude;
		logic             voice_done;
		logic [CNT_W-1:0] active_count;
	} rsp_t;

	typedef struct packed {
		phase_t              phase;
		logic [LEVEL_W-1:0]  level;
		logic [LEVEL_W-1:0]  step;
		logic [TICK_W-1:0]   ticks;
	} entry_t;

	// Divider request and response
	typedef struct packed {
		logic               start;
		logic [LEVEL_W-1:0] num;
		logic [TICK_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

[design/paeb_div.sv]
// Radix-2 restoring divider: 32-bit numerator by 18-bit denominator.
// One quotient bit per cycle; done is high for a single cycle, registered with the last bit.
// Depends on paeb_pkg.
`default_nettype none

module paeb_div (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire paeb_pkg::div_req_t req,
	output paeb_pkg::div_rsp_t      rsp
);

	localparam int unsigned NW = paeb_pkg::LEVEL_W;
	localparam int unsigned DW = paeb_pkg::TICK_W;
	localparam int unsigned CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   shifted;
	logic          fits;

	// Trial subtract of the shifted remainder
	assign shifted = {rem_q, quo_q[NW-1]};
	assign fits    = shifted >= {1'b0, den_q};

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

`default_nettype wire

[design/polyphonic_adsr_envelope_bank_core.sv]
// Polyphonic ADSR envelope bank: per-voice state memory, sequencer, config registers.
// Depends on paeb_pkg and paeb_div.
//
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries {func, voice}:
//   press, release or tick of one voice. Only a tick of a voice below VOICES
//   returns a result on the rsp channel: {amplitude, voice_done, active_count}.
//   Requests are worked one at a time; req_ready is high only while the
//   sequencer is idle. A request reads the voice entry from a registered-read
//   memory, updates it and writes it back, so accesses never overlap.
//   Work per request, on the shared 32-iteration divider:
//     press, release           : one division
//     tick                     : amplitude division (none with no voice active)
//     tick that ends an attack : decay step division, then amplitude division
//     release of an idle voice, unused code, voice out of range: no division
//   A finished result sits in an output register; the next request is taken
//   while it waits. Only a later tick that must hand over its own result
//   holds in its last state until the receiver takes the earlier one.
//   Reset clears every voice to off with zero level via per-entry valid bits,
//   clears the active count and loads the default durations; no clearing pass
//   is needed. Users make configuration writes only while idle; no check in the core.
`default_nettype none

module polyphonic_adsr_envelope_bank_core #(
	parameter int unsigned VOICES = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  wire paeb_pkg::req_t          req_data,
	output logic                         rsp_valid,
	input  wire                          rsp_ready,
	output paeb_pkg::rsp_t               rsp_data,
	input  wire                          cfg_we,
	input  wire  [1:0]                   cfg_index,
	input  wire  [paeb_pkg::CFG_W-1:0]   cfg_data
);

	localparam int unsigned AW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int unsigned LW = paeb_pkg::LEVEL_W;
	localparam int unsigned TW = paeb_pkg::TICK_W;
	localparam int unsigned CW = paeb_pkg::CNT_W;

	paeb_pkg::state_t state_q, state_d;

	logic [TW-1:0] atk_q, dec_q, rel_q;
	logic [LW-1:0] sus_q;

	logic [1:0]        func_q;
	logic [AW-1:0]     addr_q;
	logic [VOICES-1:0] vld_q;
	paeb_pkg::entry_t  voice_mem [VOICES];
	paeb_pkg::entry_t  rd_q;
	paeb_pkg::entry_t  ent;
	paeb_pkg::entry_t  wk_q;
	paeb_pkg::entry_t  nx;
	logic              done_q, nx_done;
	logic [CW-1:0]     on_q, on_nx;
	logic [paeb_pkg::AMP_W-1:0] amp_q;
	logic              rsp_valid_q;
	paeb_pkg::rsp_t    rsp_q;

	logic          req_acc, legal;
	logic          need_div;
	logic [LW-1:0] div_num;
	logic [TW-1:0] div_den;
	logic [TW-1:0] pt1;
	logic [LW:0]   lvl_sum;
	logic [LW-1:0] lvl_sub;
	logic          live;
	logic          mem_we, out_load;

	paeb_pkg::div_req_t div_req;
	paeb_pkg::div_rsp_t div_rsp;

	assign req_acc = req_valid && req_ready;
	assign legal   = (req_data.func != paeb_pkg::FUNC_NONE)
		&& ({3'b000, req_data.voice} < 9'(VOICES));

	// Configuration registers; zero durations are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atk_q <= TW'(65535);
			dec_q <= TW'(65535);
			sus_q <= 32'h7FFF_FFFF;
			rel_q <= TW'(65535);
		end else if (cfg_we) begin
			case (cfg_index)
				paeb_pkg::CFG_ATTACK: begin
					if (cfg_data[TW-1:0] != '0) atk_q <= cfg_data[TW-1:0];
				end
				paeb_pkg::CFG_DECAY: begin
					if (cfg_data[TW-1:0] != '0) dec_q <= cfg_data[TW-1:0];
				end
				paeb_pkg::CFG_SUSTAIN: begin
					sus_q <= cfg_data;
				end
				paeb_pkg::CFG_RELEASE: begin
					if (cfg_data[TW-1:0] != '0) rel_q <= cfg_data[TW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Voice memory: read on accept, write back at the end of the request
	always_ff @(posedge clk) begin
		if (req_acc) begin
			rd_q <= voice_mem[AW'(req_data.voice)];
		end
		if (mem_we) begin
			voice_mem[addr_q] <= wk_q;
		end
	end

	// Valid bits stand in for the reset contents of the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[addr_q] <= 1'b1;
		end
	end

	assign ent = vld_q[addr_q] ? rd_q : paeb_pkg::entry_t'('0);

	// Envelope update for the voice just read
	assign pt1     = ent.ticks + 1'b1;
	assign lvl_sum = {1'b0, ent.level} + {1'b0, ent.step};
	assign lvl_sub = (ent.level > ent.step) ? (ent.level - ent.step) : '0;
	assign live    = ent.phase inside {paeb_pkg::PH_ATTACK, paeb_pkg::PH_DECAY,
		paeb_pkg::PH_SUSTAIN, paeb_pkg::PH_RELEASE};

	always_comb begin
		nx       = ent;
		nx_done  = 1'b0;
		on_nx    = on_q;
		need_div = 1'b0;
		div_num  = '0;
		div_den  = '0;
		case (func_q)
			paeb_pkg::FUNC_PRESS: begin
				if (!live && (9'(on_q) < 9'(VOICES))) on_nx = on_q + 1'b1;
				need_div  = 1'b1;
				div_num   = paeb_pkg::FULL_SCALE - ent.level;
				div_den   = atk_q;
				nx.phase  = paeb_pkg::PH_ATTACK;
				nx.ticks  = '0;
			end
			paeb_pkg::FUNC_RELEASE: begin
				if (live) begin
					need_div = 1'b1;
					div_num  = ent.level;
					div_den  = rel_q;
					nx.phase = paeb_pkg::PH_RELEASE;
					nx.ticks = '0;
				end
			end
			default: begin
				nx.ticks = pt1;
				case (ent.phase)
					paeb_pkg::PH_ATTACK: begin
						nx.level = lvl_sum[LW] ? paeb_pkg::FULL_SCALE : lvl_sum[LW-1:0];
						if (pt1 >= atk_q) begin
							nx.ticks = '0;
							nx.phase = paeb_pkg::PH_DECAY;
							need_div = 1'b1;
							div_num  = paeb_pkg::FULL_SCALE - sus_q;
							div_den  = dec_q;
						end
					end
					paeb_pkg::PH_DECAY: begin
						nx.level = lvl_sub;
						if (pt1 >= dec_q) begin
							nx.ticks = '0;
							nx.phase = paeb_pkg::PH_SUSTAIN;
							nx.step  = '0;
						end
					end
					paeb_pkg::PH_SUSTAIN: begin
						nx.level = sus_q;
					end
					paeb_pkg::PH_RELEASE: begin
						nx.level = lvl_sub;
						if (pt1 >= rel_q) begin
							nx.ticks = '0;
							nx.phase = paeb_pkg::PH_OFF;
							nx_done  = 1'b1;
							if (on_q != '0) on_nx = on_q - 1'b1;
						end
					end
					default: begin
						nx.phase = paeb_pkg::PH_OFF;
						nx.level = '0;
					end
				endcase
			end
		endcase
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			paeb_pkg::S_IDLE: begin
				if (req_valid && legal) state_d = paeb_pkg::S_READ;
			end
			paeb_pkg::S_READ: begin
				if (need_div) state_d = paeb_pkg::S_STEP;
				else if (func_q == paeb_pkg::FUNC_TICK) state_d = paeb_pkg::S_AMPGO;
				else state_d = paeb_pkg::S_IDLE;
			end
			paeb_pkg::S_STEP: begin
				if (div_rsp.done) begin
					state_d = (func_q == paeb_pkg::FUNC_TICK) ? paeb_pkg::S_AMPGO
						: paeb_pkg::S_WRITE;
				end
			end
			paeb_pkg::S_AMPGO: begin
				state_d = (on_q == '0) ? paeb_pkg::S_WRITE : paeb_pkg::S_AMP;
			end
			paeb_pkg::S_AMP: begin
				if (div_rsp.done) state_d = paeb_pkg::S_WRITE;
			end
			paeb_pkg::S_WRITE: begin
				if (func_q != paeb_pkg::FUNC_TICK || !rsp_valid_q || rsp_ready) begin
					state_d = paeb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = paeb_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_ready     = (state_q == paeb_pkg::S_IDLE);
		mem_we        = (state_q == paeb_pkg::S_WRITE) && (state_d == paeb_pkg::S_IDLE);
		out_load      = mem_we && (func_q == paeb_pkg::FUNC_TICK);
		div_req.start = 1'b0;
		div_req.num   = div_num;
		div_req.den   = div_den;
		case (state_q)
			paeb_pkg::S_READ: begin
				div_req.start = need_div;
			end
			paeb_pkg::S_AMPGO: begin
				div_req.start = (on_q != '0);
				div_req.num   = {16'h0000, wk_q.level[LW-1:16]};
				div_req.den   = TW'(on_q);
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= paeb_pkg::S_IDLE;
			on_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == paeb_pkg::S_READ) on_q <= on_nx;
			if (out_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// Request working registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_q <= req_data.func;
			addr_q <= AW'(req_data.voice);
		end
		if (state_q == paeb_pkg::S_READ) begin
			wk_q   <= nx;
			done_q <= nx_done;
		end
		if (state_q == paeb_pkg::S_STEP && div_rsp.done) begin
			wk_q.step <= div_rsp.quot;
		end
		if (state_q == paeb_pkg::S_AMPGO && on_q == '0) begin
			amp_q <= '0;
		end
		if (state_q == paeb_pkg::S_AMP && div_rsp.done) begin
			amp_q <= div_rsp.quot[paeb_pkg::AMP_W-1:0];
		end
		if (out_load) begin
			rsp_q.amplitude    <= amp_q;
			rsp_q.voice_done   <= done_q;
			rsp_q.active_count <= on_q;
		end
	end

	paeb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Active count never passes the voice count or 64
	a_on_range: assert property (@(posedge clk) disable iff (!arst_n)
		(9'(on_q) <= 9'(VOICES)) && (on_q <= 7'd64))
		else $error("active voice count out of range");

	// Divider finishes only while the sequencer waits for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == paeb_pkg::S_STEP || state_q == paeb_pkg::S_AMP))
		else $error("divider result with no waiting state");

	// A new result comes only from the write-back of a tick
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |->
			$past(state_q == paeb_pkg::S_WRITE && func_q == paeb_pkg::FUNC_TICK))
		else $error("result raised outside tick write-back");

	// Write-back never overwrites a result still waiting
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
